// ===== sv/strided_multidim_address_walker_core_assert.svh =====
// Assertion macros for the strided address walker.
`ifndef STRIDED_MULTIDIM_ADDRESS_WALKER_CORE_ASSERT_SVH
`define STRIDED_MULTIDIM_ADDRESS_WALKER_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SMAW_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define SMAW_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/smaw_pkg.sv =====
// Package with constants, types and helpers of the strided address walker.
`timescale 1ns / 1ps
`default_nettype none
package smaw_pkg;

  localparam int MAX_DIMS_DEF   = 3;
  localparam int INDEX_BITS_DEF = 32;
  localparam int NUM_CFG_DIMS   = 3;
  localparam int SRC_BITS       = 32;
  localparam int DEST_BITS      = 36;
  localparam int SIZE_BITS      = 13;
  localparam int CNT_BITS       = 12;
  localparam int STRIDE_BITS    = 32;
  localparam int CFG_IDX_BITS   = 3;
  localparam int CFG_DATA_BITS  = 32;
  localparam int DIM_CNT_BITS   = 4;
  localparam int ACT_BITS       = 2;
  localparam int MAX_ELEMS      = 4096;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_ACTIVE_DIMS = 3'd0,
    CFG_BASE_OFFSET = 3'd1,
    CFG_SIZE_DIM0   = 3'd2,
    CFG_SIZE_DIM1   = 3'd3,
    CFG_SIZE_DIM2   = 3'd4,
    CFG_STRIDE_DIM0 = 3'd5,
    CFG_STRIDE_DIM1 = 3'd6,
    CFG_STRIDE_DIM2 = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic active;
    logic top;
    logic start;
    logic advance;
  } cell_ctl_t;

  typedef struct packed {
    logic at_end;
    logic terminal;
    logic carry_out;
  } cell_stat_t;

  // Size minus one, with zero taken as one and large sizes saturated.
  function automatic logic [CNT_BITS-1:0] eff_size_m1(input logic [SIZE_BITS-1:0] s);
    logic [CNT_BITS-1:0] r;
    if (s == '0) begin
      r = '0;
    end else if (s > SIZE_BITS'(MAX_ELEMS)) begin
      r = CNT_BITS'(MAX_ELEMS - 1);
    end else begin
      r = CNT_BITS'(s - 1'b1);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== sv/smaw_req_if.sv =====
// Request channel interface of the strided address walker.
`timescale 1ns / 1ps
`default_nettype none
interface smaw_req_if;
  logic valid;
  logic ready;
  logic kind;
  logic restart;

  modport source (output valid, output kind, output restart, input ready);
  modport sink (input valid, input kind, input restart, output ready);
endinterface
`default_nettype wire

// ===== sv/smaw_rsp_if.sv =====
// Result channel interface of the strided address walker.
`timescale 1ns / 1ps
`default_nettype none
interface smaw_rsp_if;
  logic                           valid;
  logic                           ready;
  logic                           direction;
  logic [smaw_pkg::SRC_BITS-1:0]  source_index;
  logic [smaw_pkg::DEST_BITS-1:0] dest_index;
  logic                           last;

  modport source (output valid, output direction, output source_index,
                  output dest_index, output last, input ready);
  modport sink (input valid, input direction, input source_index,
                input dest_index, input last, output ready);
endinterface
`default_nettype wire

// ===== sv/smaw_cell.sv =====
// One dimension cell: counter, wrap detection and precomputed pointer step.
`timescale 1ns / 1ps
`default_nettype none
module smaw_cell #(
  parameter int INDEX_BITS = smaw_pkg::INDEX_BITS_DEF
) (
  input  logic                                 clk,
  input  smaw_pkg::cell_ctl_t                  ctl,
  input  logic [smaw_pkg::CNT_BITS-1:0]        size_m1,
  input  logic signed [smaw_pkg::STRIDE_BITS-1:0] stride,
  input  logic                                 carry_in,
  input  logic [INDEX_BITS-1:0]                prefix_in,
  output logic [INDEX_BITS-1:0]                prefix_out,
  output logic [INDEX_BITS-1:0]                delta,
  output smaw_pkg::cell_stat_t                 stat
);
  import smaw_pkg::*;

  localparam int PROD_BITS = STRIDE_BITS + CNT_BITS + 1;

  logic [CNT_BITS-1:0]         cnt;
  logic [CNT_BITS-1:0]         cnt_eff;
  logic signed [PROD_BITS-1:0] prod;
  logic [INDEX_BITS-1:0]       rewind;
  logic [INDEX_BITS-1:0]       cum;
  logic                        at_max;
  logic                        terminal;
  logic                        wrap;

  assign cnt_eff  = ctl.start ? '0 : cnt;
  assign at_max   = (cnt_eff == size_m1);
  assign terminal = carry_in & ctl.active & (~at_max | ctl.top);
  assign wrap     = carry_in & ctl.active & at_max & ~ctl.top;
  assign prod     = stride * signed'({1'b0, size_m1});
  assign delta    = terminal ? cum : '0;

  assign stat.at_end    = ~ctl.active | at_max;
  assign stat.terminal  = terminal;
  assign stat.carry_out = wrap;

  // The step taken when this cell is the first one that does not wrap is its
  // own stride less the rewinds of all cells below it.
  always_ff @(posedge clk) begin
    rewind     <= INDEX_BITS'(prod);
    prefix_out <= prefix_in + rewind;
    cum        <= INDEX_BITS'(stride) - prefix_in;
    if (ctl.advance) begin
      if (terminal) begin
        cnt <= cnt_eff + CNT_BITS'(1);
      end else if (wrap) begin
        cnt <= '0;
      end else begin
        cnt <= cnt_eff;
      end
    end
  end

endmodule
`default_nettype wire

// ===== sv/strided_multidim_address_walker_core.sv =====
// A result is registered and appears in the cycle after its request transaction.
// Throughput: one transaction per cycle while results are taken; the carry
// through the chain of dimension cells resolves in the same cycle.
// After reset and after every configuration write, req.ready stays low while
// the cells recompute their pointer steps.
// Reset restores the default registers and returns the walk to its start.
`timescale 1ns / 1ps
`default_nettype none
module strided_multidim_address_walker_core #(
  parameter int MAX_DIMS   = smaw_pkg::MAX_DIMS_DEF,
  parameter int INDEX_BITS = smaw_pkg::INDEX_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  smaw_req_if.sink                           req,
  smaw_rsp_if.source                         rsp,
  input  logic                               cfg_we,
  input  logic [smaw_pkg::CFG_IDX_BITS-1:0]  cfg_idx,
  input  logic [smaw_pkg::CFG_DATA_BITS-1:0] cfg_data
);
  import smaw_pkg::*;

  `include "strided_multidim_address_walker_core_assert.svh"

  localparam int SETTLE      = MAX_DIMS + 3;
  localparam int SETTLE_BITS = $clog2(SETTLE + 1);

  logic [ACT_BITS-1:0]           active_dims;
  logic [SRC_BITS-1:0]           base_offset;
  logic [SIZE_BITS-1:0]          size_reg [NUM_CFG_DIMS];
  logic signed [STRIDE_BITS-1:0] stride_reg [NUM_CFG_DIMS];

  logic [SETTLE_BITS-1:0] settle;
  logic                   fresh;
  logic [INDEX_BITS-1:0]  ptr;
  logic [DEST_BITS-1:0]   dest;

  logic                   start;
  logic                   req_fire;
  logic                   last_now;
  logic                   advance;
  logic [DIM_CNT_BITS-1:0] n_dims;
  logic [INDEX_BITS-1:0]  ptr_eff;
  logic [DEST_BITS-1:0]   dest_eff;
  logic [INDEX_BITS-1:0]  delta_sum;

  cell_ctl_t             ctl [MAX_DIMS];
  cell_stat_t            stat [MAX_DIMS];
  logic [MAX_DIMS-1:0]   carry;
  logic [MAX_DIMS-1:0]   at_end;
  logic [MAX_DIMS-1:0]   terminal;
  logic [INDEX_BITS-1:0] prefix [MAX_DIMS];
  logic [INDEX_BITS-1:0] delta [MAX_DIMS];

  assign n_dims   = (DIM_CNT_BITS'(active_dims) > DIM_CNT_BITS'(MAX_DIMS)) ?
                    DIM_CNT_BITS'(MAX_DIMS) : DIM_CNT_BITS'(active_dims);
  assign start    = fresh | req.restart;
  assign ptr_eff  = start ? INDEX_BITS'(base_offset) : ptr;
  assign dest_eff = start ? '0 : dest;
  assign req.ready = (settle == '0) && (!rsp.valid || rsp.ready);
  assign req_fire = req.valid && req.ready;
  assign last_now = &at_end;
  assign advance  = req_fire && !last_now;
  assign carry[0] = 1'b1;
  assign prefix[0] = '0;

  for (genvar j = 0; j < MAX_DIMS; j++) begin : g_cell
    logic [CNT_BITS-1:0]           sm1;
    logic signed [STRIDE_BITS-1:0] st;

    if (j < NUM_CFG_DIMS) begin : g_cfg
      assign sm1 = eff_size_m1(size_reg[j]);
      assign st  = stride_reg[j];
    end else begin : g_fixed
      assign sm1 = '0;
      assign st  = '0;
    end

    if (j > 0) begin : g_carry
      assign carry[j] = stat[j-1].carry_out;
    end

    assign ctl[j].active  = DIM_CNT_BITS'(j) < n_dims;
    assign ctl[j].top     = (DIM_CNT_BITS'(j) + DIM_CNT_BITS'(1)) == n_dims;
    assign ctl[j].start   = start;
    assign ctl[j].advance = advance;
    assign at_end[j]      = stat[j].at_end;
    assign terminal[j]    = stat[j].terminal;

    if (j == MAX_DIMS - 1) begin : g_tail
      smaw_cell #(.INDEX_BITS(INDEX_BITS)) u_cell (
        .clk        (clk),
        .ctl        (ctl[j]),
        .size_m1    (sm1),
        .stride     (st),
        .carry_in   (carry[j]),
        .prefix_in  (prefix[j]),
        .prefix_out (),
        .delta      (delta[j]),
        .stat       (stat[j])
      );
    end else begin : g_body
      smaw_cell #(.INDEX_BITS(INDEX_BITS)) u_cell (
        .clk        (clk),
        .ctl        (ctl[j]),
        .size_m1    (sm1),
        .stride     (st),
        .carry_in   (carry[j]),
        .prefix_in  (prefix[j]),
        .prefix_out (prefix[j+1]),
        .delta      (delta[j]),
        .stat       (stat[j])
      );
    end
  end

  always_comb begin
    delta_sum = '0;
    for (int j = 0; j < MAX_DIMS; j++) begin
      delta_sum = delta_sum | delta[j];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active_dims   <= ACT_BITS'(1);
      base_offset   <= '0;
      size_reg[0]   <= SIZE_BITS'(1);
      size_reg[1]   <= SIZE_BITS'(1);
      size_reg[2]   <= SIZE_BITS'(1);
      stride_reg[0] <= STRIDE_BITS'(1);
      stride_reg[1] <= '0;
      stride_reg[2] <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_ACTIVE_DIMS: active_dims   <= cfg_data[ACT_BITS-1:0];
        CFG_BASE_OFFSET: base_offset   <= cfg_data[SRC_BITS-1:0];
        CFG_SIZE_DIM0:   size_reg[0]   <= cfg_data[SIZE_BITS-1:0];
        CFG_SIZE_DIM1:   size_reg[1]   <= cfg_data[SIZE_BITS-1:0];
        CFG_SIZE_DIM2:   size_reg[2]   <= cfg_data[SIZE_BITS-1:0];
        CFG_STRIDE_DIM0: stride_reg[0] <= cfg_data[STRIDE_BITS-1:0];
        CFG_STRIDE_DIM1: stride_reg[1] <= cfg_data[STRIDE_BITS-1:0];
        CFG_STRIDE_DIM2: stride_reg[2] <= cfg_data[STRIDE_BITS-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      settle    <= SETTLE_BITS'(SETTLE);
      fresh     <= 1'b1;
      rsp.valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        settle <= SETTLE_BITS'(SETTLE);
      end else if (settle != '0) begin
        settle <= settle - SETTLE_BITS'(1);
      end
      if (cfg_we) begin
        fresh <= 1'b1;
      end else if (req_fire) begin
        fresh <= last_now;
      end
      if (req_fire) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_fire) begin
      rsp.direction    <= req.kind;
      rsp.source_index <= SRC_BITS'(ptr_eff);
      rsp.dest_index   <= dest_eff;
      rsp.last         <= last_now;
      ptr              <= ptr_eff + delta_sum;
      dest             <= dest_eff + DEST_BITS'(1);
    end
  end

  `SMAW_ASSERT_NEXT(a_cfg_blocks_req, clk, rst, cfg_we, !req.ready, "request accepted while settling")
  `SMAW_ASSERT_NEXT(a_restart_dest, clk, rst, req_fire && req.restart, rsp.dest_index == '0, "restart did not start at zero")
  `SMAW_ASSERT_NEXT(a_last_rewinds, clk, rst, req_fire && last_now, fresh, "walk not rewound after last")
  `SMAW_ASSERT_IMP(a_one_terminal, clk, rst, 1'b1, $onehot0(terminal), "more than one terminal cell")

endmodule
`default_nettype wire

// ===== tb/sv/tb_strided_multidim_address_walker_core.sv =====
`timescale 1ns / 1ps
// Testbench that drives the strided address walker and checks each address it issues.
module tb_strided_multidim_address_walker_core;
  import smaw_pkg::*;

  typedef struct packed {
    logic                 direction;
    logic [SRC_BITS-1:0]  source_index;
    logic [DEST_BITS-1:0] dest_index;
    logic                 last;
  } element_addr_t;

  typedef struct {
    logic          is_write;
    cfg_idx_t      reg_idx;
    logic [31:0]   reg_value;
    logic          kind;
    logic          restart;
    logic          known;
    element_addr_t known_addr;
  } plan_row_t;

  localparam element_addr_t NO_ADDR = '0;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     cfg_we;
  logic [CFG_IDX_BITS-1:0]  cfg_idx;
  logic [CFG_DATA_BITS-1:0] cfg_data;

  smaw_req_if req_ch ();
  smaw_rsp_if rsp_ch ();

  strided_multidim_address_walker_core dut (
    .clk      (clk),
    .rst      (rst),
    .req      (req_ch),
    .rsp      (rsp_ch),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the walker's registers and walk state.
  logic [1:0]           m_dims;
  logic [31:0]          m_base;
  logic [SIZE_BITS-1:0] m_size [3];
  logic [31:0]          m_stride [3];
  logic [SRC_BITS-1:0]  m_ptr;
  logic [DEST_BITS-1:0] m_dest;
  logic [SIZE_BITS-1:0] m_cnt [3];

  element_addr_t pending_addrs [$];
  int            mismatches = 0;
  int            req_gap_max = 0;
  int            rsp_gap_max = 0;
  logic          hold_off = 1'b0;

  function automatic logic [SIZE_BITS-1:0] dim_span(input int j);
    logic [SIZE_BITS-1:0] s;
    s = m_size[j];
    if (s == '0) return SIZE_BITS'(1);
    if (s > SIZE_BITS'(MAX_ELEMS)) return SIZE_BITS'(MAX_ELEMS);
    return s;
  endfunction

  function automatic void rewind_walk();
    m_ptr  = m_base;
    m_dest = '0;
    foreach (m_cnt[j]) m_cnt[j] = '0;
  endfunction

  function automatic void apply_reg(input cfg_idx_t idx, input logic [31:0] v);
    case (idx)
      CFG_ACTIVE_DIMS: m_dims = v[1:0];
      CFG_BASE_OFFSET: m_base = v;
      CFG_SIZE_DIM0:   m_size[0] = v[SIZE_BITS-1:0];
      CFG_SIZE_DIM1:   m_size[1] = v[SIZE_BITS-1:0];
      CFG_SIZE_DIM2:   m_size[2] = v[SIZE_BITS-1:0];
      CFG_STRIDE_DIM0: m_stride[0] = v;
      CFG_STRIDE_DIM1: m_stride[1] = v;
      CFG_STRIDE_DIM2: m_stride[2] = v;
      default: ;
    endcase
    rewind_walk();
  endfunction

  // Issues the address of the current element, then steps the walk.
  function automatic element_addr_t walk_next(input logic k, input logic r);
    element_addr_t res;
    logic          done;
    int            n;
    n = int'(m_dims);
    if (r) rewind_walk();
    done = 1'b1;
    for (int j = 0; j < n; j++)
      if (m_cnt[j] != dim_span(j) - 1'b1) done = 1'b0;
    res = '{k, m_ptr, m_dest, done};
    if (done) begin
      rewind_walk();
    end else begin
      for (int j = 0; j < n; j++) begin
        m_ptr = m_ptr + m_stride[j];
        m_cnt[j] = m_cnt[j] + 1'b1;
        if (j == n - 1 || m_cnt[j] < dim_span(j)) break;
        m_cnt[j] = '0;
        m_ptr = m_ptr - m_stride[j] * SRC_BITS'(dim_span(j));
      end
      m_dest = m_dest + 1'b1;
    end
    return res;
  endfunction

  function automatic plan_row_t cfg_row(input cfg_idx_t idx, input logic [31:0] v);
    return '{1'b1, idx, v, 1'b0, 1'b0, 1'b0, NO_ADDR};
  endfunction

  function automatic plan_row_t item_row(input logic k, input logic r);
    return '{1'b0, CFG_ACTIVE_DIMS, 32'd0, k, r, 1'b0, NO_ADDR};
  endfunction

  function automatic plan_row_t known_row(input logic k, input logic r,
                                          input logic [31:0] src, input logic lst);
    return '{1'b0, CFG_ACTIVE_DIMS, 32'd0, k, r, 1'b1, '{k, src, 36'd0, lst}};
  endfunction

  task automatic write_reg(input cfg_idx_t idx, input logic [31:0] v);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= v;
    apply_reg(idx, v);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic send_item(input logic k, input logic r, input logic known,
                           input element_addr_t known_addr);
    element_addr_t res;
    int            gap;
    gap = $urandom_range(0, req_gap_max);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid   <= 1'b1;
    req_ch.kind    <= k;
    req_ch.restart <= r;
    do @(posedge clk); while (!req_ch.ready);
    res = walk_next(k, r);
    pending_addrs.push_back(known ? known_addr : res);
  endtask

  task automatic drain_walk();
    req_ch.valid <= 1'b0;
    while (pending_addrs.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  initial begin
    int            gap;
    element_addr_t want;
    element_addr_t got;
    rsp_ch.ready = 1'b0;
    @(negedge rst);
    forever begin
      if (hold_off) begin
        gap = 150;
        hold_off = 1'b0;
      end else begin
        gap = $urandom_range(0, rsp_gap_max);
      end
      if (gap > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk); while (rsp_ch.valid !== 1'b1);
      got = '{rsp_ch.direction, rsp_ch.source_index, rsp_ch.dest_index, rsp_ch.last};
      if (pending_addrs.size() == 0) begin
        $error("transaction with nothing expected: source_index %h dest_index %h",
               got.source_index, got.dest_index);
        mismatches++;
      end else begin
        want = pending_addrs.pop_front();
        if (got.direction !== want.direction) begin
          $error("direction mismatch: expected %h, actual %h", want.direction, got.direction);
          mismatches++;
        end
        if (got.source_index !== want.source_index) begin
          $error("source_index mismatch: expected %h, actual %h",
                 want.source_index, got.source_index);
          mismatches++;
        end
        if (got.dest_index !== want.dest_index) begin
          $error("dest_index mismatch: expected %h, actual %h",
                 want.dest_index, got.dest_index);
          mismatches++;
        end
        if (got.last !== want.last) begin
          $error("last mismatch: expected %h, actual %h", want.last, got.last);
          mismatches++;
        end
      end
    end
  end

  initial begin
    plan_row_t   plan [$];
    logic [31:0] vals [8];
    cfg_idx_t    r;
    int          nd;
    int          n_items;
    cfg_we         = 1'b0;
    cfg_idx        = '0;
    cfg_data       = '0;
    req_ch.valid   = 1'b0;
    req_ch.kind    = 1'b0;
    req_ch.restart = 1'b0;
    m_dims    = 2'd1;
    m_base    = '0;
    m_size    = '{default: SIZE_BITS'(1)};
    m_stride  = '{32'd1, 32'd0, 32'd0};
    rewind_walk();
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed part: defaults, the empty view, wrap of the source index,
    // size zero and saturated sizes, extreme strides and a restart mid-walk.
    plan.push_back(known_row(1'b0, 1'b0, 32'h0000_0000, 1'b1));
    plan.push_back(known_row(1'b1, 1'b0, 32'h0000_0000, 1'b1));
    plan.push_back(cfg_row(CFG_ACTIVE_DIMS, 32'd0));
    plan.push_back(cfg_row(CFG_BASE_OFFSET, 32'hFFFF_FFFF));
    plan.push_back(known_row(1'b0, 1'b1, 32'hFFFF_FFFF, 1'b1));
    plan.push_back(known_row(1'b1, 1'b0, 32'hFFFF_FFFF, 1'b1));
    plan.push_back(cfg_row(CFG_ACTIVE_DIMS, 32'd1));
    plan.push_back(cfg_row(CFG_SIZE_DIM0, 32'd3));
    plan.push_back(cfg_row(CFG_STRIDE_DIM0, 32'h7FFF_FFFF));
    plan.push_back(item_row(1'b0, 1'b0));
    plan.push_back(item_row(1'b1, 1'b0));
    plan.push_back(item_row(1'b0, 1'b0));
    plan.push_back(item_row(1'b1, 1'b0));
    plan.push_back(cfg_row(CFG_BASE_OFFSET, 32'd0));
    plan.push_back(cfg_row(CFG_ACTIVE_DIMS, 32'd3));
    plan.push_back(cfg_row(CFG_SIZE_DIM0, 32'd2));
    plan.push_back(cfg_row(CFG_SIZE_DIM1, 32'd0));
    plan.push_back(cfg_row(CFG_SIZE_DIM2, 32'd2));
    plan.push_back(cfg_row(CFG_STRIDE_DIM0, 32'h8000_0000));
    plan.push_back(cfg_row(CFG_STRIDE_DIM1, 32'h0001_2345));
    plan.push_back(cfg_row(CFG_STRIDE_DIM2, 32'hFFFF_FFFF));
    plan.push_back(item_row(1'b0, 1'b0));
    plan.push_back(item_row(1'b1, 1'b0));
    plan.push_back(item_row(1'b0, 1'b1));
    plan.push_back(item_row(1'b1, 1'b0));
    plan.push_back(item_row(1'b0, 1'b0));
    plan.push_back(item_row(1'b1, 1'b0));
    plan.push_back(cfg_row(CFG_SIZE_DIM0, 32'h0000_1FFF));
    plan.push_back(cfg_row(CFG_SIZE_DIM2, 32'h0000_1000));
    plan.push_back(cfg_row(CFG_ACTIVE_DIMS, 32'd2));
    plan.push_back(cfg_row(CFG_SIZE_DIM1, 32'd1));
    plan.push_back(item_row(1'b1, 1'b0));
    plan.push_back(item_row(1'b0, 1'b0));

    req_gap_max = 17;
    rsp_gap_max = 17;
    foreach (plan[i]) begin
      if (plan[i].is_write) begin
        drain_walk();
        write_reg(plan[i].reg_idx, plan[i].reg_value);
      end else begin
        send_item(plan[i].kind, plan[i].restart, plan[i].known, plan[i].known_addr);
      end
    end

    // Random walks over small views, some with a saturated outer dimension, with restarts and full-range strides.
    for (int ph = 0; ph < 12; ph++) begin
      drain_walk();
      nd = $urandom_range(0, 3);
      vals[CFG_ACTIVE_DIMS] = 32'(nd);
      case ($urandom_range(0, 3))
        0:       vals[CFG_BASE_OFFSET] = 32'h0000_0000;
        1:       vals[CFG_BASE_OFFSET] = 32'hFFFF_FFFF;
        default: vals[CFG_BASE_OFFSET] = $urandom;
      endcase
      for (int j = 0; j < 3; j++) begin
        case ($urandom_range(0, 9))
          0:       vals[CFG_SIZE_DIM0 + j] = 32'd0;
          1:       vals[CFG_SIZE_DIM0 + j] = (j >= nd - 1) ? $urandom_range(4096, 8191)
                                                           : $urandom_range(1, 4);
          default: vals[CFG_SIZE_DIM0 + j] = $urandom_range(1, 4);
        endcase
        case ($urandom_range(0, 4))
          0:       vals[CFG_STRIDE_DIM0 + j] = 32'h8000_0000;
          1:       vals[CFG_STRIDE_DIM0 + j] = 32'h7FFF_FFFF;
          2:       vals[CFG_STRIDE_DIM0 + j] = $urandom;
          default: vals[CFG_STRIDE_DIM0 + j] = 32'($urandom_range(0, 16)) - 32'd8;
        endcase
      end
      r = r.first();
      do begin
        if (ph == 0 || $urandom_range(0, 3) != 0) write_reg(r, vals[r]);
        r = r.next();
      end while (r != r.first());

      req_gap_max = (ph % 3 == 0) ? 0 : 17;
      rsp_gap_max = (ph % 3 == 0) ? 0 : 17;
      if (ph == 4) begin
        req_gap_max = 0;
        hold_off = 1'b1;
      end
      n_items = $urandom_range(20, 40);
      repeat (n_items)
        send_item(1'($urandom_range(0, 1)), ($urandom_range(0, 11) == 0), 1'b0, NO_ADDR);
    end

    // A saturated inner dimension under a second active dimension.
    drain_walk();
    write_reg(CFG_ACTIVE_DIMS, 32'd2);
    write_reg(CFG_BASE_OFFSET, $urandom);
    write_reg(CFG_SIZE_DIM0, $urandom_range(4096, 8191));
    write_reg(CFG_SIZE_DIM1, 32'd2);
    write_reg(CFG_STRIDE_DIM0, $urandom);
    write_reg(CFG_STRIDE_DIM1, $urandom);
    req_gap_max = 0;
    rsp_gap_max = 0;
    repeat (30) send_item(1'($urandom_range(0, 1)), 1'b0, 1'b0, NO_ADDR);

    drain_walk();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && pending_addrs.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+sv
sv/smaw_pkg.sv
sv/smaw_req_if.sv
sv/smaw_rsp_if.sv
sv/smaw_cell.sv
sv/strided_multidim_address_walker_core.sv
tb/sv/tb_strided_multidim_address_walker_core.sv
